### src/multi_press_long_press_keys_top_assert.svh
// Assertion macros for the multi-press / long-press key detector.
`ifndef MULTI_PRESS_LONG_PRESS_KEYS_TOP_ASSERT_SVH
`define MULTI_PRESS_LONG_PRESS_KEYS_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define MPLPK_ASSERT(lbl, clock, reset, prop, msg) \
  lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define MPLPK_ASSERT_ALWAYS(lbl, clock, prop, msg) \
  lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define MPLPK_ASSERT(lbl, clock, reset, prop, msg)
`define MPLPK_ASSERT_ALWAYS(lbl, clock, prop, msg)
`endif

`endif

### src/mplpk_pkg.sv
// Shared types and constants of the multi-press / long-press key detector.
package mplpk_pkg;

  localparam int unsigned NUM_LANES = 3;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned KEY_W     = 2;
  localparam int unsigned EV_W      = 3;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic [EV_W-1:0] EV_NONE = 3'd0;
  localparam logic [EV_W-1:0] EV_LONG = 3'd4;
  localparam logic [1:0]      MAX_COUNT = 2'd3;

  localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd1000;
  localparam logic [CFG_W-1:0] WINDOW_RESET     = 16'd400;

  typedef enum logic [0:0] {
    REG_LONG_PRESS = 1'b0,
    REG_WINDOW     = 1'b1
  } cfg_reg_t;

  // Per-lane result of one poll.
  typedef struct packed {
    logic [EV_W-1:0] ev;
    logic            click;
    logic            active;
  } lane_res_t;

endpackage

### src/mplpk_lane.sv
// One key lane: hold timing, click counting and event decision.
module mplpk_lane (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           advance,
  input  logic                           down,
  input  logic [mplpk_pkg::TIME_W-1:0]   now_ms,
  input  logic [mplpk_pkg::CFG_W-1:0]    long_press_ms,
  input  logic [mplpk_pkg::CFG_W-1:0]    multi_press_window_ms,
  output mplpk_pkg::lane_res_t           res
);
  import mplpk_pkg::*;

  logic [1:0]        click_count, click_count_next;
  logic [TIME_W-1:0] first_click_time, first_click_time_next;
  logic [TIME_W-1:0] hold_start_time, hold_start_time_next;
  logic              was_down, was_down_next;
  logic              long_done, long_done_next;

  logic [TIME_W-1:0] hold_elapsed;
  logic [TIME_W-1:0] click_elapsed;
  logic [TIME_W-1:0] window_elapsed;
  logic [TIME_W-1:0] long_limit;
  logic [TIME_W-1:0] window_limit;
  logic [1:0]        count_mid;
  logic              first_restart;

  assign hold_elapsed  = now_ms - hold_start_time;
  assign click_elapsed = now_ms - first_click_time;
  assign long_limit    = {{(TIME_W-CFG_W){1'b0}}, long_press_ms};
  assign window_limit  = {{(TIME_W-CFG_W){1'b0}}, multi_press_window_ms};

  always_comb begin
    click_count_next      = click_count;
    first_click_time_next = first_click_time;
    hold_start_time_next  = hold_start_time;
    was_down_next         = was_down;
    long_done_next        = long_done;
    count_mid             = click_count;
    first_restart         = 1'b0;
    res                   = '0;

    if (down) begin
      res.active = 1'b1;
      if (!was_down) begin
        was_down_next        = 1'b1;
        hold_start_time_next = now_ms;
        long_done_next       = 1'b0;
      end else if (!long_done && (hold_elapsed >= long_limit)) begin
        long_done_next = 1'b1;
        count_mid      = 2'd0;
        res.ev         = EV_LONG;
      end
    end else begin
      if (was_down && !long_done) begin
        res.active = 1'b1;
        res.click  = 1'b1;
        if ((click_count == 2'd0) || (click_elapsed < window_limit)) begin
          if (click_count == 2'd0) begin
            first_click_time_next = now_ms;
            first_restart         = 1'b1;
          end
          if (click_count < MAX_COUNT) begin
            count_mid = click_count + 2'd1;
          end
        end else begin
          count_mid             = 2'd1;
          first_click_time_next = now_ms;
          first_restart         = 1'b1;
        end
      end
      was_down_next = 1'b0;
    end

    // A first click taken this poll has zero elapsed time.
    window_elapsed   = first_restart ? '0 : click_elapsed;
    click_count_next = count_mid;
    if ((count_mid != 2'd0) && (window_elapsed >= window_limit)) begin
      res.ev           = {1'b0, count_mid};
      click_count_next = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      click_count      <= 2'd0;
      first_click_time <= '0;
      hold_start_time  <= '0;
      was_down         <= 1'b0;
      long_done        <= 1'b0;
    end else if (advance) begin
      click_count      <= click_count_next;
      first_click_time <= first_click_time_next;
      hold_start_time  <= hold_start_time_next;
      was_down         <= was_down_next;
      long_done        <= long_done_next;
    end
  end

endmodule

### src/multi_press_long_press_keys_top.sv
// Top level of the multi-press / long-press key detector.
//
// channel  dir  handshake              payload
// s_*      in   s_tvalid / s_tready    s_tdata: now_ms, pressed_key
// m_*      out  m_tvalid / m_tready    m_tdata: events, clicks, activity
// cfg_*    in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One poll per cycle sustained while the output is not stalled; a poll's result
// passes through the input register, then the lane logic into the output register.
// The lane state update of one poll is a subtract and compare per key lane.
// Reset (synchronous) clears lane state and loads the default hold and window.
// A stalled output holds its beat; the input register still takes a beat
// when the output is free or being drained in the same cycle.
module multi_press_long_press_keys_top #(
  parameter int unsigned NUM_KEYS = 3
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [31:0] now_ms, [33:32] pressed_key, [39:34] zero
  input  logic [mplpk_pkg::IN_DATA_W-1:0]   s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [2:0] event_key1, [5:3] event_key2, [8:6] event_key3, [9] click_key1,
  // [10] click_key2, [11] click_key3, [12] activity, [15:13] zero
  output logic [mplpk_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  mplpk_pkg::cfg_reg_t               cfg_index,
  input  logic [mplpk_pkg::CFG_W-1:0]       cfg_data
);
  import mplpk_pkg::*;

  logic [CFG_W-1:0]  long_press_ms;
  logic [CFG_W-1:0]  multi_press_window_ms;

  logic              s1_valid;
  logic [TIME_W-1:0] s1_now;
  logic [KEY_W-1:0]  s1_key;
  logic              advance;

  lane_res_t         res [NUM_LANES];
  logic [NUM_LANES-1:0] act_bits;
  logic [OUT_DATA_W-1:0] out_word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ms         <= LONG_PRESS_RESET;
      multi_press_window_ms <= WINDOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LONG_PRESS: long_press_ms         <= cfg_data;
        REG_WINDOW:     multi_press_window_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_now <= s_tdata[TIME_W-1:0];
      s1_key <= s_tdata[TIME_W +: KEY_W];
    end
  end

  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    if (k < NUM_KEYS) begin : g_on
      mplpk_lane u_lane (
        .clk                   (clk),
        .rst                   (rst),
        .advance               (advance),
        .down                  (s1_key == KEY_W'(k + 1)),
        .now_ms                (s1_now),
        .long_press_ms         (long_press_ms),
        .multi_press_window_ms (multi_press_window_ms),
        .res                   (res[k])
      );
    end else begin : g_off
      assign res[k] = '0;
    end
    assign act_bits[k] = res[k].active;
  end

  assign out_word = {3'b000, |act_bits,
                     res[2].click, res[1].click, res[0].click,
                     res[2].ev, res[1].ev, res[0].ev};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= out_word;
    end
  end

`include "multi_press_long_press_keys_top_assert.svh"

  `MPLPK_ASSERT(a_event_code, clk, rst,
    m_tvalid |-> (m_tdata[2:0] <= EV_LONG) && (m_tdata[5:3] <= EV_LONG)
      && (m_tdata[8:6] <= EV_LONG),
    "event code out of range")
  `MPLPK_ASSERT(a_long_no_click, clk, rst,
    m_tvalid && (m_tdata[2:0] == EV_LONG) |-> !m_tdata[9],
    "long event and click on one key")
  `MPLPK_ASSERT(a_click_active, clk, rst,
    m_tvalid && (m_tdata[11:9] != 3'b000) |-> m_tdata[12],
    "click without activity")
  `MPLPK_ASSERT(a_stall_cause, clk, rst,
    !s_tready |-> s1_valid && m_tvalid && !m_tready,
    "input stalled without a full pipe")
  `MPLPK_ASSERT(a_result_follows, clk, rst, advance |=> m_tvalid,
    "result lost after advance")

endmodule

### verif/multi_press_long_press_keys_top_test.sv
// Self-checking testbench for the three-key multi-press / long-press detector.
module multi_press_long_press_keys_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mplpk_pkg::*;

  localparam int unsigned KEY_LANES   = 3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SHOW_LIMIT  = 10;

  // m_tdata layout, highest field first
  typedef struct packed {
    logic [2:0]                pad;
    logic                      activity;
    logic [KEY_LANES-1:0]      click;
    logic [KEY_LANES-1:0][EV_W-1:0] ev;
  } keys_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_reg_t              cfg_index = REG_LONG_PRESS;
  logic [CFG_W-1:0]      cfg_data = '0;

  // predicted detector state
  logic [CFG_W-1:0] hold_ms;
  logic [CFG_W-1:0] window_ms;
  logic [1:0]       clicks     [KEY_LANES];
  logic [31:0]      first_at   [KEY_LANES];
  logic [31:0]      hold_from  [KEY_LANES];
  logic             lane_down  [KEY_LANES];
  logic             long_fired [KEY_LANES];

  keys_result_t pending_results[$];
  logic [31:0]  now_cursor = '0;
  logic         no_idle = 1'b0;
  int           ready_wait = 0;
  int           mismatches = 0;
  int           results_seen = 0;
  int           polls_sent = 0;
  int           settings_written = 0;
  int unsigned  cycles = 0;

  multi_press_long_press_keys_top #(.NUM_KEYS(KEY_LANES)) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycles, pending_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic void clear_detector();
    int k;
    hold_ms   = LONG_PRESS_RESET;
    window_ms = WINDOW_RESET;
    for (k = 0; k < KEY_LANES; k++) begin
      clicks[k]     = '0;
      first_at[k]   = '0;
      hold_from[k]  = '0;
      lane_down[k]  = 1'b0;
      long_fired[k] = 1'b0;
    end
  endfunction

  // Advance the key lanes by one poll and return the events it produces.
  function automatic keys_result_t detect_keys(input logic [31:0] now, input logic [1:0] key);
    keys_result_t r;
    logic [31:0]  since;
    int           k;
    r = '0;
    for (k = 0; k < KEY_LANES; k++) begin
      if (key == k + 1) begin
        r.activity = 1'b1;
        since = now - hold_from[k];
        if (!lane_down[k]) begin
          lane_down[k]  = 1'b1;
          hold_from[k]  = now;
          long_fired[k] = 1'b0;
        end else if (!long_fired[k] && since >= {16'b0, hold_ms}) begin
          long_fired[k] = 1'b1;
          clicks[k]     = '0;
          r.ev[k]       = EV_LONG;
        end
      end else begin
        if (lane_down[k] && !long_fired[k]) begin
          r.activity = 1'b1;
          r.click[k] = 1'b1;
          since = now - first_at[k];
          if (clicks[k] == 0 || since < {16'b0, window_ms}) begin
            if (clicks[k] == 0) first_at[k] = now;
            if (clicks[k] < MAX_COUNT) clicks[k] = clicks[k] + 2'd1;
          end else begin
            // window already over: this click starts a new count
            clicks[k]   = 2'd1;
            first_at[k] = now;
          end
        end
        lane_down[k] = 1'b0;
      end
    end
    for (k = 0; k < KEY_LANES; k++) begin
      since = now - first_at[k];
      if (clicks[k] != 0 && since >= {16'b0, window_ms}) begin
        r.ev[k]   = {1'b0, clicks[k]};
        clicks[k] = '0;
      end
    end
    return r;
  endfunction

  function automatic void flag_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= SHOW_LIMIT)
      $display("Mismatch on %s at result %0d: expected %0d, got %0d",
               what, results_seen, want, got);
  endfunction

  // Send one poll beat; valid stays high afterward unless the next poll idles.
  task automatic send_poll(input logic [31:0] now, input logic [1:0] key);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, key, now};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(detect_keys(now, key));
    polls_sent++;
  endtask

  task automatic step_to(input logic [1:0] key, input int unsigned dt);
    now_cursor = now_cursor + dt;
    send_poll(now_cursor, key);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_setting(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_LONG_PRESS) hold_ms = value;
    else window_ms = value;
    settings_written++;
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin : result_check
    keys_result_t want;
    keys_result_t got;
    int k;
    if (rst) begin
      m_tready   <= 1'b0;
      ready_wait = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = keys_result_t'(m_tdata);
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOW_LIMIT)
            $display("Unexpected result beat %h with nothing pending", m_tdata);
        end else begin
          want = pending_results.pop_front();
          for (k = 0; k < KEY_LANES; k++) begin
            if (got.ev[k] !== want.ev[k])
              flag_mismatch($sformatf("event_key%0d", k + 1), want.ev[k], got.ev[k]);
            if (got.click[k] !== want.click[k])
              flag_mismatch($sformatf("click_key%0d", k + 1), want.click[k], got.click[k]);
          end
          if (got.activity !== want.activity)
            flag_mismatch("activity", want.activity, got.activity);
        end
        results_seen++;
        ready_wait = no_idle ? 0 : $urandom_range(0, 5);
      end
      if (ready_wait > 0) begin
        m_tready <= 1'b0;
        ready_wait--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Reset settings: double click, long press across the timestamp wrap, count saturation.
  task automatic test_default_timing();
    send_poll(32'd0, 2'd0);
    send_poll(32'd100, 2'd1);
    send_poll(32'd150, 2'd0);
    send_poll(32'd300, 2'd1);
    send_poll(32'd320, 2'd0);
    send_poll(32'd550, 2'd0);
    send_poll(32'hFFFF_FF00, 2'd2);
    send_poll(32'h0000_02E7, 2'd2);
    send_poll(32'h0000_02E8, 2'd2);
    send_poll(32'h0000_0300, 2'd2);
    send_poll(32'h0000_0310, 2'd0);
    send_poll(32'h0000_1000, 2'd3);
    send_poll(32'h0000_1001, 2'd0);
    send_poll(32'h0000_1002, 2'd3);
    send_poll(32'h0000_1003, 2'd0);
    send_poll(32'h0000_1004, 2'd3);
    send_poll(32'h0000_1005, 2'd0);
    send_poll(32'h0000_1006, 2'd3);
    send_poll(32'h0000_1007, 2'd0);
    send_poll(32'h0000_1191, 2'd0);
  endtask

  // Zero hold and window: long on the second poll, click reported at once.
  task automatic test_zero_times();
    write_setting(REG_LONG_PRESS, 16'd0);
    write_setting(REG_WINDOW, 16'd0);
    send_poll(32'd10, 2'd1);
    send_poll(32'd10, 2'd1);
    send_poll(32'd12, 2'd0);
    send_poll(32'd20, 2'd2);
    send_poll(32'd21, 2'd0);
  endtask

  task automatic test_full_scale_times();
    write_setting(REG_LONG_PRESS, 16'hFFFF);
    write_setting(REG_WINDOW, 16'hFFFF);
    send_poll(32'hFFFF_FFFF, 2'd1);
    send_poll(32'h0000_FFFD, 2'd1);
    send_poll(32'h0000_FFFE, 2'd1);
    send_poll(32'h0001_0000, 2'd0);
  endtask

  // Mostly well-formed press gestures on random keys, plus noise polls.
  task automatic run_gestures(input int n_polls);
    int          target;
    int          presses;
    int          holds;
    int          p;
    int          i;
    int unsigned lp;
    int unsigned win;
    int unsigned total;
    logic [1:0]  key;
    lp     = hold_ms;
    win    = window_ms;
    target = polls_sent + n_polls;
    while (polls_sent < target) begin
      if ($urandom_range(0, 99) < 8) no_idle = ~no_idle;
      if ($urandom_range(0, 9) < 7) begin
        key     = 2'($urandom_range(1, 3));
        presses = $urandom_range(1, 4);
        for (p = 0; p < presses; p++) begin
          if ($urandom_range(0, 3) != 0) step_to(key, $urandom_range(0, win / 2));
          else step_to(key, $urandom_range(win, 2 * win));
          holds = $urandom_range(1, 3);
          if ($urandom_range(0, 3) == 0) total = $urandom_range(lp, 2 * lp);
          else total = $urandom_range(0, lp - 1);
          for (i = 0; i < holds; i++) step_to(key, (total + holds - 1) / holds);
          step_to(2'd0, $urandom_range(0, win / 4));
        end
        step_to(2'd0, $urandom_range(win / 2, 2 * win));
      end else begin
        repeat ($urandom_range(1, 5)) begin
          if ($urandom_range(0, 7) == 0) now_cursor = $urandom;
          step_to(2'($urandom_range(0, 3)), $urandom_range(0, 2 * (lp + win)));
        end
      end
    end
    no_idle = 1'b0;
  endtask

  task automatic random_phase(input logic [CFG_W-1:0] lp, input logic [CFG_W-1:0] win);
    write_setting(REG_LONG_PRESS, lp);
    write_setting(REG_WINDOW, win);
    now_cursor = $urandom;
    run_gestures(320);
  endtask

  task automatic test_random_gestures();
    random_phase(16'd60, 16'd40);
    random_phase(16'd1, 16'd1);
    random_phase(16'hFFFF, 16'hFFFF);
    random_phase(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
    random_phase(16'd300, 16'd120);
    random_phase(16'($urandom_range(1, 400)), 16'($urandom_range(1, 200)));
  endtask

  initial begin
    clear_detector();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_timing();
    test_zero_times();
    test_full_scale_times();
    test_random_gestures();

    drain();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      mismatches++;
      $display("%0d expected results never arrived", pending_results.size());
    end

    $display("Checked %0d results from %0d polls across %0d register writes",
             results_seen, polls_sent, settings_written);
    $display("Covered clicks, multi-press counts, long presses, timestamp wrap and idle/stall gaps");
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
